>>> rtl/core/cpc_pkg.sv
package cpc_pkg;

    // Target modes
    typedef enum logic [1:0] {
        TGT_RASTER    = 2'd0,
        TGT_GREY      = 2'd1,
        TGT_COMPONENT = 2'd2,
        TGT_MASK      = 2'd3
    } target_mode_t;

    // Scalar source selection
    typedef enum logic [1:0] {
        SMP_LUMA      = 2'd0,
        SMP_ALPHA     = 2'd1,
        SMP_COMPONENT = 2'd2,
        SMP_RED       = 2'd3
    } sample_mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_MODE = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_MODE = 2'd1;
    localparam logic [1:0] CFG_COMPONENT   = 2'd2;

    // Luminance weights, sum is 65536
    localparam logic [15:0] LUM_R = 16'd19595;
    localparam logic [15:0] LUM_G = 16'd38470;
    localparam logic [15:0] LUM_B = 16'd7471;

    localparam logic [16:0] FULL_COV = 17'd65536;

    // Quotient bits of the raster colour divider (twice the byte, plus round bit)
    localparam int DIV_QW = 9;
    localparam int DIV_NW = 49;
    localparam int DIV_DW = 41;

    // Side data that rides along the divider stages
    typedef struct packed {
        target_mode_t      tm;
        logic [1:0]        ci;
        logic [3:0][7:0]   dst;
        logic [2:0][7:0]   fb;     // colour bytes used when output alpha is zero
        logic [7:0]        ab;     // raster alpha byte
        logic              wz;     // output alpha weight is zero
        logic [3:0][7:0]   sc;     // scalar blend bytes per channel
    } side_t;

    // Saturate to a byte
    function automatic logic [7:0] sat8(input logic [16:0] v);
        sat8 = (v > 17'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

>>> rtl/core/cpc_div_pipe.sv
module cpc_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 41,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic [QW-1:0] en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int RW = NW + 1;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    // One restoring step per stage, most significant quotient bit first
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [NW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [QW-1:0] quo_prev;
        logic [RW-1:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_prev = num;
            assign den_prev = den;
            assign quo_prev = '0;
        end else begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign den_prev = den_reg[j-1];
            assign quo_prev = quo_reg[j-1];
        end

        assign trial = RW'(rem_prev) - (RW'(den_prev) << (QW - 1 - j));
        assign ge    = ~trial[RW-1];

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= ge ? trial[NW-1:0] : rem_prev;
                den_reg[j] <= den_prev;
                quo_reg[j] <= {quo_prev[QW-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

>>> rtl/core/clone_pixel_compositor.sv
// Clone-stamp pixel compositor.
// Input channel (in_valid/in_ready): one destination RGBA8 pixel, a Q0.16
// source RGBA sample and a Q1.16 coverage per transfer. Output channel
// (out_valid/out_ready): one RGBA8 pixel per input transfer, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// 0 target mode, 1 sample mode, 2 component index, other indexes ignored.
// Write it only while no pixel is in flight.
// Throughput: one pixel per cycle while the output is not stalled. A pixel
// passes 13 register stages (the first loaded by the transfer) on its way
// to out_valid: three arithmetic stages, nine one-bit steps of the raster
// colour divider and the output register.
// Each stage has its own valid bit; a stalled receiver holds the output
// register, and bubbles ahead of it keep filling, so in_ready drops only
// once every stage holds a pixel.
// Reset clears all valid bits and sets every mode register to zero.
module clone_pixel_compositor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  dst_red,
    input  logic [7:0]  dst_green,
    input  logic [7:0]  dst_blue,
    input  logic [7:0]  dst_alpha,
    input  logic [15:0] src_red,
    input  logic [15:0] src_green,
    input  logic [15:0] src_blue,
    input  logic [15:0] src_alpha,
    input  logic [16:0] coverage,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    import cpc_pkg::*;

    localparam int DIV0 = 3;
    localparam int NS   = DIV0 + DIV_QW + 1;
    localparam int OUTS = NS - 1;

    // Configuration registers
    target_mode_t tm_reg;
    sample_mode_t sm_reg;
    logic [1:0]   ci_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tm_reg <= TGT_RASTER;
            sm_reg <= SMP_LUMA;
            ci_reg <= 2'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TARGET_MODE: tm_reg <= target_mode_t'(cfg_data);
                CFG_SAMPLE_MODE: sm_reg <= sample_mode_t'(cfg_data);
                CFG_COMPONENT:   ci_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Stage flow control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = ~v_reg[i] | en[i+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Stage 0: coverage clamp, alpha weights, luminance terms
    logic [16:0]       cl;
    logic [16:0]       c0_reg, cb0_reg;
    logic [31:0]       a0_reg;
    logic [23:0]       b0_reg;
    logic [2:0][31:0]  l0_reg;
    logic [3:0][7:0]   d0_reg;
    logic [3:0][15:0]  s0_reg;
    target_mode_t      tm0_reg;
    sample_mode_t      sm0_reg;
    logic [1:0]        ci0_reg;

    assign cl = (coverage > FULL_COV) ? FULL_COV : coverage;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c0_reg    <= cl;
            cb0_reg   <= FULL_COV - cl;
            a0_reg    <= 32'(src_alpha) * 32'(cl);
            b0_reg    <= 24'(dst_alpha) * 24'(FULL_COV - cl);
            l0_reg[0] <= 32'(LUM_R) * 32'(src_red);
            l0_reg[1] <= 32'(LUM_G) * 32'(src_green);
            l0_reg[2] <= 32'(LUM_B) * 32'(src_blue);
            d0_reg    <= {dst_alpha, dst_blue, dst_green, dst_red};
            s0_reg    <= {src_alpha, src_blue, src_green, src_red};
            tm0_reg   <= tm_reg;
            sm0_reg   <= sm_reg;
            ci0_reg   <= ci_reg;
        end
    end

    // Stage 1: output alpha weight, colour products, scalar pick
    logic [31:0]       v1;
    logic [40:0]       w1_reg;
    logic [2:0][47:0]  p1_reg;
    logic [2:0][31:0]  q1_reg;
    logic [2:0][32:0]  m1_reg;
    logic [3:0][23:0]  f1_reg;
    logic [31:0]       v1_reg;
    logic [16:0]       c1_reg;
    logic [3:0][7:0]   d1_reg;
    target_mode_t      tm1_reg;
    logic [1:0]        ci1_reg;

    always_comb
    begin
        unique case (sm0_reg)
            SMP_LUMA:      v1 = l0_reg[0] + l0_reg[1] + l0_reg[2];
            SMP_ALPHA:     v1 = {s0_reg[3], 16'd0};
            SMP_COMPONENT: v1 = {s0_reg[ci0_reg], 16'd0};
            SMP_RED:       v1 = {s0_reg[0], 16'd0};
            default:       v1 = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            w1_reg <= (41'(a0_reg) << 8) - 41'(a0_reg) + (41'(b0_reg) << 16);
            for (int k = 0; k < 3; k++)
            begin
                p1_reg[k] <= 48'(s0_reg[k]) * 48'(a0_reg);
                q1_reg[k] <= 32'(d0_reg[k]) * 32'(b0_reg);
                m1_reg[k] <= 33'(s0_reg[k]) * 33'(c0_reg);
            end
            for (int k = 0; k < 4; k++)
                f1_reg[k] <= 24'(d0_reg[k]) * 24'(cb0_reg);
            v1_reg  <= v1;
            c1_reg  <= c0_reg;
            d1_reg  <= d0_reg;
            tm1_reg <= tm0_reg;
            ci1_reg <= ci0_reg;
        end
    end

    // Stage 2: colour numerators, zero-alpha fallback, alpha byte
    logic [2:0][63:0]  n2;
    logic [2:0][48:0]  z2;
    logic [40:0]       wr2;
    logic [2:0][48:0]  nn2_reg;
    logic [40:0]       w2_reg;
    logic [48:0]       vc2_reg;
    logic [3:0][23:0]  f2_reg;
    side_t             side2_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            n2[k] = (64'(p1_reg[k]) << 16) - (64'(p1_reg[k]) << 9) + 64'(p1_reg[k])
                  + (64'(q1_reg[k]) << 32);
            z2[k] = (49'(m1_reg[k]) << 8) - 49'(m1_reg[k]) + (49'(f1_reg[k]) << 16)
                  + (49'd1 << 31);
        end
        wr2 = w1_reg + (41'd1 << 31);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                nn2_reg[k]      <= n2[k][63:15];
                side2_reg.fb[k] <= sat8(z2[k][48:32]);
            end
            w2_reg        <= w1_reg;
            vc2_reg       <= 49'(v1_reg) * 49'(c1_reg);
            f2_reg        <= f1_reg;
            side2_reg.tm  <= tm1_reg;
            side2_reg.ci  <= ci1_reg;
            side2_reg.dst <= d1_reg;
            side2_reg.ab  <= sat8(17'(wr2[40:32]));
            side2_reg.wz  <= (w1_reg == 41'd0);
            side2_reg.sc  <= '0;
        end
    end

    // Raster colour dividers, one per colour channel
    logic [2:0][DIV_QW-1:0] quo;

    for (genvar k = 0; k < 3; k++) begin : g_div
        cpc_div_pipe #(
            .NW (DIV_NW),
            .DW (DIV_DW),
            .QW (DIV_QW)
        ) u_div (
            .clk (clk),
            .en  (en[DIV0 +: DIV_QW]),
            .num (nn2_reg[k]),
            .den (w2_reg),
            .quo (quo[k])
        );
    end

    // Side data along the divider stages; scalar blend in the first of them
    side_t            side_reg [DIV0:OUTS-1];
    logic [3:0][56:0] x3;
    side_t            side3;

    always_comb
    begin
        side3 = side2_reg;
        for (int k = 0; k < 4; k++)
        begin
            x3[k] = (57'(vc2_reg) << 8) - 57'(vc2_reg) + (57'(f2_reg[k]) << 32)
                  + (57'd1 << 47);
            side3.sc[k] = sat8(17'(x3[k][56:48]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV0])
            side_reg[DIV0] <= side3;
        for (int i = DIV0 + 1; i < OUTS; i++)
            if (en[i])
                side_reg[i] <= side_reg[i-1];
    end

    // Output stage: mode select and divider rounding
    side_t           so;
    logic [3:0][7:0] res;
    logic [9:0]      qr;

    assign so = side_reg[OUTS-1];

    always_comb
    begin
        res = so.dst;
        qr  = '0;
        unique case (so.tm)
            TGT_RASTER:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qr     = (10'(quo[k]) + 10'd1) >> 1;
                    res[k] = so.wz ? so.fb[k] : sat8(17'(qr));
                end
                res[3] = so.ab;
            end
            TGT_GREY:
            begin
                for (int k = 0; k < 3; k++)
                    res[k] = so.sc[k];
            end
            TGT_COMPONENT:
                res[so.ci] = so.sc[so.ci];
            TGT_MASK:
                res = {24'd0, so.sc[0]};
            default: ;
        endcase
    end

    logic [3:0][7:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en[OUTS])
            out_reg <= res;
    end

    assign out_valid = v_reg[OUTS];
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = out_reg[3];

endmodule

>>> rtl/core/cpc_checker.sv
module cpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       cfg_ready
);

    // A clock edge under reset leaves no result offered
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // An empty output register means the pipe can always take a pixel
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
            && $stable(out_blue) && $stable(out_alpha))
        else $error("result changed while stalled");

    // Configuration writes are never refused out of reset
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready low");

endmodule

bind clone_pixel_compositor cpc_checker u_cpc_checker (.*);
